>>> hdl/assert_macros.svh
// Assertion macros used by the port-level checker of the polygon centroid block.
// Each macro wraps one clocked concurrent assertion with an active-low reset guard.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: ante |-> cons
`define PMC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: ante |=> cons
`define PMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/pmc_pkg.sv
// Shared types and constants of the polygon centroid block.
// No dependencies; every other source file of the block but assert_macros.svh imports it.
package pmc_pkg;

    // Q8.8 coordinate width, fixed by the word format
    localparam int COORD_W = 16;
    // cross product x_a*y_b - x_b*y_a, exact
    localparam int CR_W    = 2 * COORD_W + 1;
    localparam int ST_W    = 2;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_FEW  = 2'd1;
    localparam logic [ST_W-1:0] ST_AREA = 2'd2;

    // Phases of one edge through the shared multiplier
    localparam logic [1:0] PH_CROSS_P = 2'd0;
    localparam logic [1:0] PH_CROSS_N = 2'd1;
    localparam logic [1:0] PH_MOM_X   = 2'd2;
    localparam logic [1:0] PH_MOM_Y   = 2'd3;

    typedef struct packed {
        logic       en;
        logic [1:0] phase;
        logic       clear;
    } t_mac_ctl;

endpackage

>>> hdl/pmc_stream_if.sv
// Valid/ready channel interfaces for vertex words in and centroid words out.
// Depends on pmc_pkg for the coordinate and status widths.
interface pmc_vertex_if;
    import pmc_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic                      last_vertex;

    modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
    modport sink   (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

interface pmc_result_if;
    import pmc_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] centroid_x;
    logic signed [COORD_W-1:0] centroid_y;
    logic [ST_W-1:0]           status;

    modport source (output valid, centroid_x, centroid_y, status, input ready);
    modport sink   (input valid, centroid_x, centroid_y, status, output ready);
endinterface

>>> hdl/polygon_mass_centroid.sv
// Polygon centroid by the shoelace formula. The first vertex is only stored; each later
// vertex is accepted, then makes four passes of the shared multiplier; a closing vertex
// of three or more adds the closing passes, the area test, two divisions (one quotient
// bit per cycle) and the output load. A new vertex is taken only once the last is done;
// one polygon result per closing pass. Synchronous active-low reset clears the vertex
// count, the sums and the output valid; no clearing pass.
module polygon_mass_centroid #(
    parameter int MAX_VERTICES = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pmc_vertex_if.sink   i_vtx,
    pmc_result_if.source o_res
);
    import pmc_pkg::*;

    localparam int AREA_W   = 2 * COORD_W + $clog2(MAX_VERTICES) + 2;
    localparam int MOMENT_W = 3 * COORD_W + $clog2(MAX_VERTICES) + 4;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EDGE  = 3'd1;
    localparam logic [2:0] S_CLOSE = 3'd2;
    localparam logic [2:0] S_TEST  = 3'd3;
    localparam logic [2:0] S_DIVX  = 3'd4;
    localparam logic [2:0] S_DIVY  = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    localparam logic [1:0] SEEN_MAX = 2'd3;
    localparam logic [1:0] SEEN_TWO = 2'd2;

    logic [2:0]                r_state;
    logic [1:0]                r_phase;
    logic [1:0]                r_seen;
    logic                      r_last;
    logic signed [COORD_W-1:0] r_cur_x, r_cur_y;
    logic signed [COORD_W-1:0] r_first_x, r_first_y;
    logic signed [COORD_W-1:0] r_prev_x, r_prev_y;
    logic signed [COORD_W-1:0] r_cx, r_cy;
    logic [ST_W-1:0]           r_st;
    logic                      r_out_valid;
    logic signed [COORD_W-1:0] r_out_x, r_out_y;
    logic [ST_W-1:0]           r_out_st;

    logic [1:0]                w_seen_inc;
    logic                      w_fin_load;
    logic                      w_close;
    t_mac_ctl                  w_mac_ctl;
    logic signed [COORD_W-1:0] w_ax, w_ay, w_bx, w_by;
    logic signed [AREA_W-1:0]  w_area;
    logic signed [MOMENT_W-1:0] w_mom_x, w_mom_y;
    logic                      w_area_pos;
    logic                      w_div_start;
    logic                      w_div_done;
    logic signed [COORD_W-1:0] w_div_q;
    logic signed [MOMENT_W-1:0] w_div_num;

    // midpoint (a + b) / 2, rounded half away from zero
    function automatic logic [COORD_W-1:0] f_mid(input logic signed [COORD_W-1:0] a,
                                                 input logic signed [COORD_W-1:0] b);
        logic [COORD_W:0] s;
        logic [COORD_W:0] mag;
        logic [COORD_W:0] half;
        s    = {a[COORD_W-1], a} + {b[COORD_W-1], b};
        mag  = s[COORD_W] ? (~s + 1'b1) : s;
        half = (mag + 1'b1) >> 1;
        return s[COORD_W] ? COORD_W'(~half + 1'b1) : COORD_W'(half);
    endfunction

    assign w_seen_inc = (r_seen == SEEN_MAX) ? SEEN_MAX : r_seen + 2'd1;
    assign w_fin_load = (r_state == S_FIN) && (!r_out_valid || o_res.ready);
    assign w_close    = (r_state == S_CLOSE);

    // edge operands: previous to current, or current back to first on close
    assign w_ax = w_close ? r_cur_x   : r_prev_x;
    assign w_ay = w_close ? r_cur_y   : r_prev_y;
    assign w_bx = w_close ? r_first_x : r_cur_x;
    assign w_by = w_close ? r_first_y : r_cur_y;

    assign w_mac_ctl.en    = (r_state == S_EDGE) || w_close;
    assign w_mac_ctl.phase = r_phase;
    assign w_mac_ctl.clear = w_fin_load;

    pmc_edge_mac #(
        .AREA_W   (AREA_W),
        .MOMENT_W (MOMENT_W)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_ax    (w_ax),
        .i_ay    (w_ay),
        .i_bx    (w_bx),
        .i_by    (w_by),
        .o_area  (w_area),
        .o_mom_x (w_mom_x),
        .o_mom_y (w_mom_y)
    );

    assign w_area_pos  = !w_area[AREA_W-1] && (|w_area);
    assign w_div_start = ((r_state == S_TEST) && w_area_pos) ||
                         ((r_state == S_DIVX) && w_div_done);
    assign w_div_num   = (r_state == S_DIVX) ? w_mom_y : w_mom_x;

    pmc_div #(
        .AREA_W   (AREA_W),
        .MOMENT_W (MOMENT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_area  (w_area),
        .o_done  (w_div_done),
        .o_quot  (w_div_q)
    );

    // sequencer: accept a vertex, run its edges, close, divide, deliver
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_CROSS_P;
            r_seen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_res.ready && !w_fin_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_vtx.valid) begin
                        r_cur_x <= i_vtx.vertex_x;
                        r_cur_y <= i_vtx.vertex_y;
                        r_last  <= i_vtx.last_vertex;
                        if (r_seen == '0) begin
                            r_first_x <= i_vtx.vertex_x;
                            r_first_y <= i_vtx.vertex_y;
                            r_prev_x  <= i_vtx.vertex_x;
                            r_prev_y  <= i_vtx.vertex_y;
                            r_seen    <= 2'd1;
                            if (i_vtx.last_vertex) begin
                                r_cx    <= '0;
                                r_cy    <= '0;
                                r_st    <= ST_FEW;
                                r_state <= S_FIN;
                            end
                        end else begin
                            r_phase <= PH_CROSS_P;
                            r_state <= S_EDGE;
                        end
                    end
                end
                S_EDGE: begin
                    r_phase <= r_phase + 2'd1;
                    if (r_phase == PH_MOM_Y) begin
                        r_prev_x <= r_cur_x;
                        r_prev_y <= r_cur_y;
                        r_seen   <= w_seen_inc;
                        if (!r_last) begin
                            r_state <= S_IDLE;
                        end else if (w_seen_inc == SEEN_TWO) begin
                            r_cx    <= f_mid(r_first_x, r_cur_x);
                            r_cy    <= f_mid(r_first_y, r_cur_y);
                            r_st    <= ST_OK;
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_CLOSE;
                        end
                    end
                end
                S_CLOSE: begin
                    r_phase <= r_phase + 2'd1;
                    if (r_phase == PH_MOM_Y) begin
                        r_state <= S_TEST;
                    end
                end
                S_TEST: begin
                    // clockwise or degenerate polygons report an error
                    if (w_area_pos) begin
                        r_state <= S_DIVX;
                    end else begin
                        r_cx    <= '0;
                        r_cy    <= '0;
                        r_st    <= ST_AREA;
                        r_state <= S_FIN;
                    end
                end
                S_DIVX: begin
                    if (w_div_done) begin
                        r_cx    <= w_div_q;
                        r_state <= S_DIVY;
                    end
                end
                S_DIVY: begin
                    if (w_div_done) begin
                        r_cy    <= w_div_q;
                        r_st    <= ST_OK;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // hold until the output register is free, then clear for the next polygon
                    if (w_fin_load) begin
                        r_out_x     <= r_cx;
                        r_out_y     <= r_cy;
                        r_out_st    <= r_st;
                        r_out_valid <= 1'b1;
                        r_seen      <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_vtx.ready      = (r_state == S_IDLE);
    assign o_res.valid      = r_out_valid;
    assign o_res.centroid_x = r_out_x;
    assign o_res.centroid_y = r_out_y;
    assign o_res.status     = r_out_st;

endmodule

>>> hdl/pmc_edge_mac.sv
// Shared multiplier with cross product register and area / moment accumulators.
// Depends on pmc_pkg; one edge takes four phases, one product per cycle while enabled.
module pmc_edge_mac #(
    parameter int AREA_W   = 42,
    parameter int MOMENT_W = 60
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pmc_pkg::t_mac_ctl                 i_ctl,
    input  logic signed [pmc_pkg::COORD_W-1:0] i_ax,
    input  logic signed [pmc_pkg::COORD_W-1:0] i_ay,
    input  logic signed [pmc_pkg::COORD_W-1:0] i_bx,
    input  logic signed [pmc_pkg::COORD_W-1:0] i_by,
    output logic signed [AREA_W-1:0]          o_area,
    output logic signed [MOMENT_W-1:0]        o_mom_x,
    output logic signed [MOMENT_W-1:0]        o_mom_y
);
    import pmc_pkg::*;

    localparam int PROD_W = COORD_W + 1 + CR_W;

    logic signed [COORD_W:0]   w_sum_x;
    logic signed [COORD_W:0]   w_sum_y;
    logic signed [COORD_W:0]   w_op_a;
    logic signed [CR_W-1:0]    w_op_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [CR_W-1:0]    r_cr;
    logic signed [AREA_W-1:0]  r_area;
    logic signed [MOMENT_W-1:0] r_mom_x;
    logic signed [MOMENT_W-1:0] r_mom_y;

    // edge coordinate sums for the moment terms
    assign w_sum_x = {i_ax[COORD_W-1], i_ax} + {i_bx[COORD_W-1], i_bx};
    assign w_sum_y = {i_ay[COORD_W-1], i_ay} + {i_by[COORD_W-1], i_by};

    // select multiplier operands by phase
    always_comb begin
        unique case (i_ctl.phase)
            PH_CROSS_P: begin
                w_op_a = {i_ax[COORD_W-1], i_ax};
                w_op_b = {{(CR_W-COORD_W){i_by[COORD_W-1]}}, i_by};
            end
            PH_CROSS_N: begin
                w_op_a = {i_bx[COORD_W-1], i_bx};
                w_op_b = {{(CR_W-COORD_W){i_ay[COORD_W-1]}}, i_ay};
            end
            PH_MOM_X: begin
                w_op_a = w_sum_x;
                w_op_b = r_cr;
            end
            default: begin
                w_op_a = w_sum_y;
                w_op_b = r_cr;
            end
        endcase
    end

    assign w_prod = w_op_a * w_op_b;

    // accumulate one product per cycle while enabled; sums wrap at their widths
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area  <= '0;
            r_mom_x <= '0;
            r_mom_y <= '0;
        end else if (i_ctl.clear) begin
            r_area  <= '0;
            r_mom_x <= '0;
            r_mom_y <= '0;
        end else if (i_ctl.en) begin
            case (i_ctl.phase)
                PH_CROSS_P: r_cr <= w_prod[CR_W-1:0];
                PH_CROSS_N: r_cr <= r_cr - w_prod[CR_W-1:0];
                PH_MOM_X: begin
                    r_area  <= r_area + {{(AREA_W-CR_W){r_cr[CR_W-1]}}, r_cr};
                    r_mom_x <= r_mom_x + {{(MOMENT_W-PROD_W){w_prod[PROD_W-1]}}, w_prod};
                end
                default: begin
                    r_mom_y <= r_mom_y + {{(MOMENT_W-PROD_W){w_prod[PROD_W-1]}}, w_prod};
                end
            endcase
        end
    end

    assign o_area  = r_area;
    assign o_mom_x = r_mom_x;
    assign o_mom_y = r_mom_y;

endmodule

>>> hdl/pmc_div.sv
// Restoring divider: round(moment / (3 * area)), ties away from zero, saturated.
// Depends on pmc_pkg; one compare/subtract unit, one quotient bit per cycle.
module pmc_div #(
    parameter int AREA_W   = 42,
    parameter int MOMENT_W = 60
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [MOMENT_W-1:0]         i_num,
    input  logic [AREA_W-1:0]                  i_area,
    output logic                               o_done,
    output logic signed [pmc_pkg::COORD_W-1:0] o_quot
);
    import pmc_pkg::*;

    localparam int QW = COORD_W;
    localparam int DW = AREA_W + 2;
    localparam int RW = (MOMENT_W + 1 > DW + QW) ? MOMENT_W + 1 : DW + QW;
    localparam int CW = $clog2(QW);

    localparam logic [2:0] D_IDLE  = 3'd0;
    localparam logic [2:0] D_ADD   = 3'd1;
    localparam logic [2:0] D_CHECK = 3'd2;
    localparam logic [2:0] D_STEP  = 3'd3;
    localparam logic [2:0] D_SAT   = 3'd4;

    localparam logic [QW-1:0] Q_HALF = {1'b1, {(QW-1){1'b0}}};
    localparam logic [QW-1:0] Q_MAX  = {1'b0, {(QW-1){1'b1}}};

    logic [2:0]          r_state;
    logic [RW-1:0]       r_rem;
    logic [RW-1:0]       r_dsh;
    logic [DW-1:0]       r_d;
    logic [QW-1:0]       r_q;
    logic [CW-1:0]       r_cnt;
    logic                r_ovf;
    logic                r_neg;
    logic                r_done;
    logic signed [QW-1:0] r_quot;
    logic [MOMENT_W-1:0] w_mag;
    logic [RW:0]         w_diff;
    logic                w_borrow;

    assign w_mag    = i_num[MOMENT_W-1] ? (~i_num + 1'b1) : i_num;
    // shared compare/subtract unit
    assign w_diff   = {1'b0, r_rem} - {1'b0, r_dsh};
    assign w_borrow = w_diff[RW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            // flag the quotient for one cycle after the clamp step
            r_done <= (r_state == D_SAT);
            unique case (r_state)
                D_IDLE: begin
                    // load 2*|n| and d = 3*area
                    if (i_start) begin
                        r_rem   <= RW'({w_mag, 1'b0});
                        r_d     <= DW'({i_area, 1'b0}) + DW'(i_area);
                        r_neg   <= i_num[MOMENT_W-1];
                        r_state <= D_ADD;
                    end
                end
                D_ADD: begin
                    // numerator 2*|n| + d, divisor 2*d aligned one bit above the top quotient bit
                    r_rem   <= r_rem + RW'(r_d);
                    r_dsh   <= RW'(r_d) << (QW + 1);
                    r_state <= D_CHECK;
                end
                D_CHECK: begin
                    // quotient past the coordinate range always saturates
                    r_ovf   <= !w_borrow;
                    r_dsh   <= r_dsh >> 1;
                    r_cnt   <= CW'(QW - 1);
                    r_state <= D_STEP;
                end
                D_STEP: begin
                    if (!w_borrow) begin
                        r_rem <= w_diff[RW-1:0];
                    end
                    r_q   <= {r_q[QW-2:0], !w_borrow};
                    r_dsh <= r_dsh >> 1;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= D_SAT;
                    end
                end
                D_SAT: begin
                    // apply sign and clamp to the signed coordinate range
                    if (r_neg) begin
                        r_quot <= (r_ovf || r_q > Q_HALF) ? Q_HALF : (~r_q + 1'b1);
                    end else begin
                        r_quot <= (r_ovf || r_q[QW-1]) ? Q_MAX : r_q;
                    end
                    r_state <= D_IDLE;
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

>>> hdl/pmc_checker.sv
// Port-level checker for the polygon centroid block, bound to the top level.
// Depends on pmc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pmc_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               i_in_ready,
    input logic                               i_in_last,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic signed [pmc_pkg::COORD_W-1:0] i_cx,
    input logic signed [pmc_pkg::COORD_W-1:0] i_cy,
    input logic [pmc_pkg::ST_W-1:0]           i_status
);
    import pmc_pkg::*;

    logic [1:0] r_pend;
    logic [1:0] n_pend;

    // count closing words accepted whose results are not yet taken
    always_comb begin
        n_pend = r_pend + {1'b0, i_in_valid && i_in_ready && i_in_last}
                        - {1'b0, i_out_valid && i_out_ready};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
    end

    `PMC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_cx) && $stable(i_cy) && $stable(i_status), "stalled result word changed")
    `PMC_ASSERT_IMPL(a_out_owed, i_clk, i_rst_n, i_out_valid, r_pend != 2'd0, "result word without a closing vertex")
    `PMC_ASSERT_IMPL(a_err_zero, i_clk, i_rst_n, i_out_valid && i_status != ST_OK, i_cx == '0 && i_cy == '0, "error result with nonzero centroid")
    `PMC_ASSERT_IMPL(a_busy_full, i_clk, i_rst_n, r_pend == 2'd2, !i_in_ready, "vertex taken with two results owed")

endmodule

bind polygon_mass_centroid pmc_checker u_pmc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_vtx.valid),
    .i_in_ready  (i_vtx.ready),
    .i_in_last   (i_vtx.last_vertex),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_cx        (o_res.centroid_x),
    .i_cy        (o_res.centroid_y),
    .i_status    (o_res.status)
);

>>> tb/polygon_mass_centroid_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for polygon_mass_centroid: streams vertex words and checks centroids.
// Depends on pmc_pkg, the pmc_vertex_if/pmc_result_if channels and the block itself.
module polygon_mass_centroid_tb;
    import pmc_pkg::*;

    localparam int RANDOM_VERTICES = 1850;
    localparam int MAX_LONG_POLYS  = 2;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 60;
    localparam int N_DIRECTED      = 24;
    localparam int MAX_VERTICES_TB = 256;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [ST_W-1:0]           st;
    } t_centroid;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      last;
        logic                      typed;
        t_centroid                 want;
    } t_vertex_word;

    // Directed rows: a typed result is given only where it is obvious
    localparam t_vertex_word DIRECTED [N_DIRECTED] = '{
        // lone vertex at opposite corners of the range
        '{16'h7FFF, 16'h8000, 1'b1, 1'b1, '{16'h0000, 16'h0000, ST_FEW}},
        '{16'h8000, 16'h7FFF, 1'b1, 1'b1, '{16'h0000, 16'h0000, ST_FEW}},
        // two-vertex segments pinned at the extremes
        '{16'h7FFF, 16'h7FFF, 1'b0, 1'b0, '{16'h0000, 16'h0000, ST_OK}},
        '{16'h7FFF, 16'h7FFF, 1'b1, 1'b1, '{16'h7FFF, 16'h7FFF, ST_OK}},
        '{16'h8000, 16'h8000, 1'b0, 1'b0, '{16'h0000, 16'h0000, ST_OK}},
        '{16'h8000, 16'h8000, 1'b1, 1'b1, '{16'h8000, 16'h8000, ST_OK}},
        // midpoint with a half tie on x and a negative y
        '{16'h0100, 16'hFF00, 1'b0, 1'b0, '{16'h0000, 16'h0000, ST_OK}},
        '{16'h0201, 16'h0000, 1'b1, 1'b1, '{16'h0181, 16'hFF80, ST_OK}},
        // counter-clockwise right triangle, centroid (1.0, 1.0)
        '{16'h0000, 16'h0000, 1'b0, 1'b0, '{16'h0000, 16'h0000, ST_OK}},
        '{16'h0300, 16'h0000, 1'b0, 1'b0, '{16'h0000, 16'h0000, ST_OK}},
        '{16'h0000, 16'h0300, 1'b1, 1'b1, '{16'h0100, 16'h0100, ST_OK}},
        // same triangle wound clockwise
        '{16'h0000, 16'h0000, 1'b0, 1'b0, '{16'h0000, 16'h0000, ST_OK}},
        '{16'h0000, 16'h0300, 1'b0, 1'b0, '{16'h0000, 16'h0000, ST_OK}},
        '{16'h0300, 16'h0000, 1'b1, 1'b1, '{16'h0000, 16'h0000, ST_AREA}},
        // collinear vertices, zero area
        '{16'h0000, 16'h0000, 1'b0, 1'b0, '{16'h0000, 16'h0000, ST_OK}},
        '{16'h0100, 16'h0100, 1'b0, 1'b0, '{16'h0000, 16'h0000, ST_OK}},
        '{16'h0200, 16'h0200, 1'b1, 1'b1, '{16'h0000, 16'h0000, ST_AREA}},
        // one point repeated three times
        '{16'h7FFF, 16'h7FFF, 1'b0, 1'b0, '{16'h0000, 16'h0000, ST_OK}},
        '{16'h7FFF, 16'h7FFF, 1'b0, 1'b0, '{16'h0000, 16'h0000, ST_OK}},
        '{16'h7FFF, 16'h7FFF, 1'b1, 1'b1, '{16'h0000, 16'h0000, ST_AREA}},
        // full-range square, count saturates past three
        '{16'h8000, 16'h8000, 1'b0, 1'b0, '{16'h0000, 16'h0000, ST_OK}},
        '{16'h7FFF, 16'h8000, 1'b0, 1'b0, '{16'h0000, 16'h0000, ST_OK}},
        '{16'h7FFF, 16'h7FFF, 1'b0, 1'b0, '{16'h0000, 16'h0000, ST_OK}},
        '{16'h8000, 16'h7FFF, 1'b1, 1'b0, '{16'h0000, 16'h0000, ST_OK}}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    pmc_vertex_if vtx_ch ();
    pmc_result_if res_ch ();

    polygon_mass_centroid dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vtx   (vtx_ch),
        .o_res   (res_ch)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the polygon accumulator
    logic signed [COORD_W-1:0] poly_first_x, poly_first_y;
    logic signed [COORD_W-1:0] poly_prev_x, poly_prev_y;
    logic [1:0]                poly_count;
    logic [41:0]               poly_area;
    logic [59:0]               poly_mom_x, poly_mom_y;

    t_vertex_word vertex_q [$];
    t_centroid    pending_centroids [$];
    int           random_vertices = 0;
    int           long_polys = 0;
    bit           failed = 1'b0;
    int           idle_cycles = 0;

    function automatic void clear_polygon();
        poly_first_x = '0;
        poly_first_y = '0;
        poly_prev_x  = '0;
        poly_prev_y  = '0;
        poly_count   = '0;
        poly_area    = '0;
        poly_mom_x   = '0;
        poly_mom_y   = '0;
    endfunction

    // Add one edge a->b: cross product into the area, weighted into the moments
    function automatic void accumulate_edge(longint ax, longint ay, longint bx, longint by);
        longint cr;
        longint wx;
        longint wy;
        cr         = ax * by - bx * ay;
        wx         = (ax + bx) * cr;
        wy         = (ay + by) * cr;
        poly_area  = poly_area + cr[41:0];
        poly_mom_x = poly_mom_x + wx[59:0];
        poly_mom_y = poly_mom_y + wy[59:0];
    endfunction

    // n / d rounded half away from zero, saturated to Q8.8
    function automatic logic signed [COORD_W-1:0] round_quotient(longint n,
                                                                 longint unsigned d);
        longint unsigned mag;
        longint unsigned q;
        longint unsigned neg_q;
        mag = (n < 0) ? longint'(-n) : n;
        q   = (64'd2 * mag + d) / (64'd2 * d);
        if (n < 0) begin
            if (q > 64'd32768) q = 64'd32768;
            neg_q = 64'd0 - q;
            return neg_q[COORD_W-1:0];
        end
        if (q > 64'd32767) q = 64'd32767;
        return q[COORD_W-1:0];
    endfunction

    function automatic logic signed [COORD_W-1:0] half_sum(longint a, longint b);
        longint s;
        longint mag;
        s   = a + b;
        mag = (s < 0) ? -s : s;
        mag = (mag + 1) >>> 1;
        if (s < 0) mag = -mag;
        return mag[COORD_W-1:0];
    endfunction

    // Advance the shadow state by one vertex; returns 1 when a centroid is due
    function automatic bit predict_centroid(logic signed [COORD_W-1:0] x,
                                            logic signed [COORD_W-1:0] y,
                                            logic last, output t_centroid res);
        int                unsigned cnt;
        logic signed [41:0] area_s;
        logic signed [59:0] mom_s;
        longint             area;
        longint             vx;
        longint             vy;
        vx  = x;
        vy  = y;
        cnt = poly_count;
        res = '{default: '0};
        if (cnt == 0) begin
            poly_first_x = x;
            poly_first_y = y;
        end else begin
            accumulate_edge(poly_prev_x, poly_prev_y, vx, vy);
        end
        poly_prev_x = x;
        poly_prev_y = y;
        if (cnt < 3) cnt++;
        if (!last) begin
            poly_count = cnt[1:0];
            return 1'b0;
        end
        res.st = ST_OK;
        if (cnt == 1) begin
            res.st = ST_FEW;
        end else if (cnt == 2) begin
            res.x = half_sum(poly_first_x, vx);
            res.y = half_sum(poly_first_y, vy);
        end else begin
            accumulate_edge(vx, vy, poly_first_x, poly_first_y);
            area_s = poly_area;
            area   = area_s;
            if (area <= 0) begin
                res.st = ST_AREA;
            end else begin
                mom_s = poly_mom_x;
                res.x = round_quotient(mom_s, 64'd3 * area);
                mom_s = poly_mom_y;
                res.y = round_quotient(mom_s, 64'd3 * area);
            end
        end
        clear_polygon();
        return 1'b1;
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp_coord(int v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[COORD_W-1:0];
    endfunction

    function automatic void push_vertex(logic signed [COORD_W-1:0] x,
                                        logic signed [COORD_W-1:0] y, logic last);
        t_vertex_word w;
        w = '{default: '0};
        w.x    = x;
        w.y    = y;
        w.last = last;
        vertex_q.push_back(w);
        random_vertices++;
    endfunction

    // Star-shaped polygon around a random center, angles strictly increasing (reversed if clockwise)
    function automatic void add_star_polygon(bit clockwise);
        int  n;
        int  r;
        int  cx;
        int  cy;
        int  i;
        int  px [$];
        int  py [$];
        real base;
        real step;
        real a;
        real rad;
        n    = $urandom_range(3, 10);
        r    = ($urandom_range(0, 4) == 0) ? $urandom_range(8192, 32767)
                                           : $urandom_range(32, 4096);
        cx   = int'($urandom_range(0, 32767)) - 16384;
        cy   = int'($urandom_range(0, 32767)) - 16384;
        base = ($urandom / 4294967296.0) * 6.2831853;
        step = 6.2831853 / n;
        for (i = 0; i < n; i++) begin
            a   = base + step * i + (($urandom / 4294967296.0) - 0.5) * 0.8 * step;
            rad = r * (0.4 + 0.6 * ($urandom / 4294967296.0));
            px.push_back(cx + $rtoi(rad * $cos(a)));
            py.push_back(cy + $rtoi(rad * $sin(a)));
        end
        for (i = 0; i < n; i++) begin
            if (clockwise)
                push_vertex(clamp_coord(px[n-1-i]), clamp_coord(py[n-1-i]), i == n - 1);
            else
                push_vertex(clamp_coord(px[i]), clamp_coord(py[i]), i == n - 1);
        end
    endfunction

    // Arbitrary vertices over the full range; also covers the long wrapping polygons
    function automatic void add_noise_polygon(int n);
        int          i;
        logic [31:0] bits;
        for (i = 0; i < n; i++) begin
            bits = $urandom;
            push_vertex(bits[15:0], bits[31:16], i == n - 1);
        end
    endfunction

    function automatic void build_stimulus();
        int  i;
        int  pick;
        for (i = 0; i < N_DIRECTED; i++) vertex_q.push_back(DIRECTED[i]);
        while (random_vertices < RANDOM_VERTICES) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                add_star_polygon(1'b0);
            end else if (pick < 62) begin
                add_star_polygon(1'b1);
            end else if (pick < 82) begin
                add_noise_polygon($urandom_range(1, 8));
            end else if (pick < 93) begin
                add_noise_polygon(2);
            end else if (pick < 99 || long_polys >= MAX_LONG_POLYS) begin
                add_noise_polygon(1);
            end else begin
                add_noise_polygon($urandom_range(MAX_VERTICES_TB + 1, MAX_VERTICES_TB + 24));
                long_polys++;
            end
        end
    endfunction

    // Vertex source: reset, then one word per handshake with random gaps
    initial begin : vertex_source
        t_vertex_word w;
        t_centroid    want;
        int           gap;
        bit           burst;
        vtx_ch.valid       = 1'b0;
        vtx_ch.vertex_x    = '0;
        vtx_ch.vertex_y    = '0;
        vtx_ch.last_vertex = 1'b0;
        i_rst_n            = 1'b0;
        burst              = 1'b0;
        clear_polygon();
        build_stimulus();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (vertex_q[i]) begin
            w   = vertex_q[i];
            gap = burst ? 0 : $urandom_range(0, 9);
            if ($urandom_range(0, 39) == 0) burst = !burst;
            repeat (gap) begin
                vtx_ch.valid <= 1'b0;
                @(negedge i_clk);
            end
            vtx_ch.valid       <= 1'b1;
            vtx_ch.vertex_x    <= w.x;
            vtx_ch.vertex_y    <= w.y;
            vtx_ch.last_vertex <= w.last;
            do @(posedge i_clk); while (!vtx_ch.ready);
            // Word accepted: advance the shadow state, queue the centroid if one is due
            if (predict_centroid(w.x, w.y, w.last, want))
                pending_centroids.push_back(w.typed ? w.want : want);
            @(negedge i_clk);
        end
        vtx_ch.valid <= 1'b0;

        // Drain outstanding centroids, then hold for the closing latency
        while (pending_centroids.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (!failed)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Centroid sink: random stalls, compare each word with the oldest prediction
    initial begin : centroid_sink
        t_centroid want;
        int        stall;
        bit        burst;
        res_ch.ready = 1'b0;
        burst        = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = burst ? 0 : $urandom_range(0, 9);
            if ($urandom_range(0, 15) == 0) burst = !burst;
            while (stall > 0) begin
                @(negedge i_clk);
                res_ch.ready <= 1'b0;
                stall--;
            end
            @(negedge i_clk);
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
            if (pending_centroids.size() == 0) begin
                $display("%0t unexpected centroid word: got x=%0d y=%0d status=%0d",
                         $time, res_ch.centroid_x, res_ch.centroid_y, res_ch.status);
                failed = 1'b1;
            end else begin
                want = pending_centroids.pop_front();
                if (res_ch.centroid_x !== want.x) begin
                    $display("%0t centroid_x mismatch: expected %0d got %0d",
                             $time, want.x, res_ch.centroid_x);
                    failed = 1'b1;
                end
                if (res_ch.centroid_y !== want.y) begin
                    $display("%0t centroid_y mismatch: expected %0d got %0d",
                             $time, want.y, res_ch.centroid_y);
                    failed = 1'b1;
                end
                if (res_ch.status !== want.st) begin
                    $display("%0t status mismatch: expected %0d got %0d",
                             $time, want.st, res_ch.status);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog: end the run if no word moves on either channel for too long
    always @(posedge i_clk) begin
        if ((vtx_ch.valid && vtx_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no word moved in %0d cycles", $time, WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

endmodule

>>> files.f
+incdir+hdl
hdl/pmc_pkg.sv
hdl/pmc_stream_if.sv
hdl/pmc_edge_mac.sv
hdl/pmc_div.sv
hdl/polygon_mass_centroid.sv
hdl/pmc_checker.sv
tb/polygon_mass_centroid_tb.sv
